[design/hsv_pkg.sv]
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared constants, stage words and the divide-by-255 helper for the
// HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // field widths
    localparam int HUE_W  = 13;
    localparam int CH_W   = 8;
    localparam int SEC_W  = 4;
    localparam int REM_W  = 10;
    localparam int PROD_W = 16;
    localparam int WIDE_W = 24;

    // 60 degrees in sixteenths of a degree
    localparam int SECTOR_SPAN = 960;
    // number of sector boundaries reachable by a 13-bit hue
    localparam int SECTOR_MAX  = 8;
    // 255 * 256, full scale of the q and t terms
    localparam int FRAC_SCALE  = 65280;
    // ceil(2^16 / 15) * 4: rem * 256 / 960 == (rem * 17480) >> 16 for rem < 960
    localparam int F_RECIP     = 17480;

    // sector codes; any code above five takes the last permutation
    localparam logic [SEC_W-1:0] SEC_RED_YEL  = 4'd0;
    localparam logic [SEC_W-1:0] SEC_YEL_GRN  = 4'd1;
    localparam logic [SEC_W-1:0] SEC_GRN_CYN  = 4'd2;
    localparam logic [SEC_W-1:0] SEC_CYN_BLU  = 4'd3;
    localparam logic [SEC_W-1:0] SEC_BLU_MAG  = 4'd4;

    // word after the sector and fraction stages
    typedef struct packed {
        logic              valid;
        logic [SEC_W-1:0]  sector;
        logic [CH_W-1:0]   frac;
        logic [CH_W-1:0]   sat;
        logic [CH_W-1:0]   val;
        logic [PROD_W-1:0] p_prod;
    } t_front;

    // word after the level product stages
    typedef struct packed {
        logic              valid;
        logic [SEC_W-1:0]  sector;
        logic [CH_W-1:0]   val;
        logic [CH_W-1:0]   p_lvl;
        logic [WIDE_W-1:0] q_prod;
        logic [WIDE_W-1:0] t_prod;
    } t_level;

    // exact floor(x / 255) for any 16-bit x up to 65279
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + 17'd1 + {9'd0, x[PROD_W-1:CH_W]};
        return sum[PROD_W-1:CH_W];
    endfunction

endpackage

[design/hsv_sector.sv]
// ----------------------------------------------------------------------------
// hsv_sector
// Stages one and two: splits hue into a sector and an offset, then scales
// the offset to a 1/256 fraction and forms the p numerator.
// ----------------------------------------------------------------------------
module hsv_sector
    import hsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [CH_W-1:0] i_sat,
    input  logic [CH_W-1:0] i_val,
    output t_front          o_front
);

    logic             r_s1_valid;
    logic [SEC_W-1:0] r_s1_sector;
    logic [REM_W-1:0] r_s1_rem;
    logic [CH_W-1:0]  r_s1_sat;
    logic [CH_W-1:0]  r_s1_val;

    logic [SEC_W-1:0] n_s1_sector;
    logic [HUE_W-1:0] s1_base;
    logic [HUE_W-1:0] s1_rem_full;

    t_front           r_front;
    t_front           n_front;
    logic [24:0]      s2_frac_prod;
    logic [CH_W-1:0]  s2_inv_sat;

    // sector by constant compares, base of the sector picked alongside
    always_comb begin
        n_s1_sector = '0;
        s1_base     = '0;
        for (int k = 1; k <= SECTOR_MAX; k++) begin
            if (i_hue >= HUE_W'(k * SECTOR_SPAN)) begin
                n_s1_sector = SEC_W'(k);
                s1_base     = HUE_W'(k * SECTOR_SPAN);
            end
        end
        s1_rem_full = i_hue - s1_base;
    end

    // stage one registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_sector <= n_s1_sector;
        r_s1_rem    <= s1_rem_full[REM_W-1:0];
        r_s1_sat    <= i_sat;
        r_s1_val    <= i_val;
    end

    // fraction by reciprocal multiply, p numerator
    always_comb begin
        s2_frac_prod   = {15'd0, r_s1_rem} * 25'(F_RECIP);
        s2_inv_sat     = 8'd255 - r_s1_sat;
        n_front.valid  = r_s1_valid;
        n_front.sector = r_s1_sector;
        n_front.frac   = s2_frac_prod[23:16];
        n_front.sat    = r_s1_sat;
        n_front.val    = r_s1_val;
        n_front.p_prod = {8'd0, r_s1_val} * {8'd0, s2_inv_sat};
    end

    // stage two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

[design/hsv_levels.sv]
// ----------------------------------------------------------------------------
// hsv_levels
// Stages three and four: saturation products, the p level, and the
// brightness products that carry q and t.
// ----------------------------------------------------------------------------
module hsv_levels
    import hsv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_front i_front,
    output t_level o_level
);

    logic              r_s3_valid;
    logic [SEC_W-1:0]  r_s3_sector;
    logic [CH_W-1:0]   r_s3_val;
    logic [CH_W-1:0]   r_s3_p;
    logic [PROD_W-1:0] r_s3_sf;
    logic [PROD_W-1:0] r_s3_sg;

    logic [8:0]        s3_comp;
    logic [16:0]       s3_sg_full;

    logic [PROD_W-1:0] s4_wq;
    logic [PROD_W-1:0] s4_wt;
    t_level            r_level;
    t_level            n_level;

    // s * f and s * (256 - f); the latter never exceeds 65280
    always_comb begin
        s3_comp    = 9'd256 - {1'b0, i_front.frac};
        s3_sg_full = {9'd0, i_front.sat} * {8'd0, s3_comp};
    end

    // stage three registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_front.valid;
        end
        r_s3_sector <= i_front.sector;
        r_s3_val    <= i_front.val;
        r_s3_p      <= div255(i_front.p_prod);
        r_s3_sf     <= {8'd0, i_front.sat} * {8'd0, i_front.frac};
        r_s3_sg     <= s3_sg_full[PROD_W-1:0];
    end

    // brightness times the q and t weights
    always_comb begin
        s4_wq          = PROD_W'(FRAC_SCALE) - r_s3_sf;
        s4_wt          = PROD_W'(FRAC_SCALE) - r_s3_sg;
        n_level.valid  = r_s3_valid;
        n_level.sector = r_s3_sector;
        n_level.val    = r_s3_val;
        n_level.p_lvl  = r_s3_p;
        n_level.q_prod = {16'd0, r_s3_val} * {8'd0, s4_wq};
        n_level.t_prod = {16'd0, r_s3_val} * {8'd0, s4_wt};
    end

    // stage four registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level.valid <= 1'b0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

[design/hsv_mix.sv]
// ----------------------------------------------------------------------------
// hsv_mix
// Stage five: finishes q and t and routes v, p, q, t to the color
// channels by sector.
// ----------------------------------------------------------------------------
module hsv_mix
    import hsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_level          i_level,
    output logic            o_strobe,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue
);

    logic [CH_W-1:0] q_lvl;
    logic [CH_W-1:0] t_lvl;
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;

    logic            r_strobe;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;

    // divide by 65280 as a shift by 8 and then a divide by 255
    always_comb begin
        q_lvl = div255(i_level.q_prod[WIDE_W-1:CH_W]);
        t_lvl = div255(i_level.t_prod[WIDE_W-1:CH_W]);
    end

    // sector permutation; zero saturation makes p, q, t equal v already
    always_comb begin
        case (i_level.sector)
            SEC_RED_YEL: begin
                n_red = i_level.val;  n_green = t_lvl;         n_blue = i_level.p_lvl;
            end
            SEC_YEL_GRN: begin
                n_red = q_lvl;         n_green = i_level.val;  n_blue = i_level.p_lvl;
            end
            SEC_GRN_CYN: begin
                n_red = i_level.p_lvl; n_green = i_level.val;  n_blue = t_lvl;
            end
            SEC_CYN_BLU: begin
                n_red = i_level.p_lvl; n_green = q_lvl;        n_blue = i_level.val;
            end
            SEC_BLU_MAG: begin
                n_red = t_lvl;         n_green = i_level.p_lvl; n_blue = i_level.val;
            end
            default: begin
                n_red = i_level.val;  n_green = i_level.p_lvl; n_blue = q_lvl;
            end
        endcase
    end

    // output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_level.valid;
        end
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_strobe = r_strobe;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

endmodule

[design/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pixel stream converter from hue/saturation/value to 8-bit RGB.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge with start high and busy low, one
// pixel per clock, and its RGB word appears on the o_red, o_green and o_blue
// ports, flagged by o_strobe for one cycle. The word passes through the
// five register stages of the pipeline (sector split, fraction, saturation
// products, brightness products, divide and channel select). Results cannot
// be held off, so the receiver must take every strobed word. Busy is high
// only during reset and the first cycle after it.
// Hue values above 5759 are folded into the last sector.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [CH_W-1:0]  i_saturation,
    input  logic [CH_W-1:0]  i_brightness,
    output logic             o_strobe,
    output logic [CH_W-1:0]  o_red,
    output logic [CH_W-1:0]  o_green,
    output logic [CH_W-1:0]  o_blue
);

    logic   r_busy;
    logic   accept;
    t_front front;
    t_level level;

    // busy only while coming out of reset
    always_ff @(posedge i_clk) begin
        r_busy <= !i_rst_n;
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // sector and fraction stages
    hsv_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_hue   (i_hue),
        .i_sat   (i_saturation),
        .i_val   (i_brightness),
        .o_front (front)
    );

    // level product stages
    hsv_levels u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (front),
        .o_level (level)
    );

    // channel select and output stage
    hsv_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_level  (level),
        .o_strobe (o_strobe),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

`ifndef NO_ASSERTIONS
    // every accepted pixel leaves as a strobed word
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_strobe)
        else $error("accepted pixel did not produce a word after five cycles");

    // no word without a matching accepted pixel
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 5))
        else $error("output word without a matching input pixel");

    // zero saturation gives grey at the input brightness
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(accept && (i_saturation == 8'd0), 5)) |->
        (o_red == $past(i_brightness, 5)) && (o_green == o_red) && (o_blue == o_red))
        else $error("zero saturation pixel is not grey");

    // the brightest channel always equals the input brightness
    a_max_is_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(accept, 5)) |->
        ((o_red == $past(i_brightness, 5)) || (o_green == $past(i_brightness, 5))
         || (o_blue == $past(i_brightness, 5))))
        else $error("no channel carries the input brightness");
`endif

endmodule
